// ----- rtl/ptt_pkg.sv -----
// Package for the process tree tracking table.
// Holds operation, status and sequencer codes and the fixed field widths.
// No dependencies.
`default_nettype none

package ptt_pkg;

    localparam int ID_W    = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 6;

    localparam logic [ID_W-1:0] ALL_ONES = {ID_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        K_START  = 3'd0,
        K_ADD    = 3'd1,
        K_SET    = 3'd2,
        K_GET    = 3'd3,
        K_STOP   = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NO_PARENT = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_PWAIT,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/process_tree_tracking_table_top.sv -----
// Process tree tracking table: top level with sequencer and entry memory.
// Depends on ptt_pkg and ptt_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  input   | in        | i_valid / o_ready   | i_kind, i_handle, i_proc_id
//  result  | out       | o_valid / i_ready   | o_status, o_parent_id, o_running,
//          |           |                     | o_found_child, o_root_id, o_entry_count
//
// Start, stop and unused kinds go from transfer to the execute and final steps. Add,
// set id and get parent first scan the single read port of the entry memory, one
// entry a cycle; get parent adds a read of the parent id in the parent wait step.
// Reset clears the sequencer state, count, running flag and root id but not the
// entries; entries past the count are never read. A new item is taken while the
// previous result waits; a stalled result holds the sequencer in its final state.
`default_nettype none

module process_tree_tracking_table_top
    import ptt_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [ID_W-1:0]    i_handle,
    input  wire logic [ID_W-1:0]    i_proc_id,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic [ID_W-1:0]         o_parent_id,
    output logic                    o_running,
    output logic                    o_found_child,
    output logic [ID_W-1:0]         o_root_id,
    output logic [COUNT_W-1:0]      o_entry_count
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = 2 * ID_W + IW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    // control
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_running, n_running;
    logic              r_out_valid, n_out_valid;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_h_hit, n_h_hit;
    logic              r_id_hit, n_id_hit;

    // datapath
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [ID_W-1:0]   r_handle, n_handle;
    logic [ID_W-1:0]   r_pid, n_pid;
    logic [ID_W-1:0]   r_root, n_root;
    logic [IW-1:0]     r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]     r_h_idx, n_h_idx;
    logic [IW-1:0]     r_h_par, n_h_par;
    logic [IW-1:0]     r_id_idx, n_id_idx;
    logic [IW-1:0]     r_id_par, n_id_par;
    t_status           r_res_status, n_res_status;
    logic [ID_W-1:0]   r_res_parent, n_res_parent;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [ID_W-1:0]   r_o_parent, n_o_parent;
    logic              r_o_running, n_o_running;
    logic              r_o_child, n_o_child;
    logic [ID_W-1:0]   r_o_root, n_o_root;
    logic [CW-1:0]     r_o_count, n_o_count;

    // entry memory: {handle, id, parent index}
    logic              ram_we, ram_re;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;
    logic [ID_W-1:0]   rd_handle, rd_id;
    logic [IW-1:0]     rd_par;

    assign rd_handle = ram_rdata[EW-1 -: ID_W];
    assign rd_id     = ram_rdata[IW +: ID_W];
    assign rd_par    = ram_rdata[IW-1:0];

    ptt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_running    = r_running;
        n_out_valid  = r_out_valid;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_h_hit      = r_h_hit;
        n_id_hit     = r_id_hit;
        n_kind       = r_kind;
        n_handle     = r_handle;
        n_pid        = r_pid;
        n_root       = r_root;
        n_cmp_idx    = r_cmp_idx;
        n_h_idx      = r_h_idx;
        n_h_par      = r_h_par;
        n_id_idx     = r_id_idx;
        n_id_par     = r_id_par;
        n_res_status = r_res_status;
        n_res_parent = r_res_parent;
        n_o_status   = r_o_status;
        n_o_parent   = r_o_parent;
        n_o_running  = r_o_running;
        n_o_child    = r_o_child;
        n_o_root     = r_o_root;
        n_o_count    = r_o_count;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_rd_idx[IW-1:0];

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind       = i_kind;
                    n_handle     = i_handle;
                    n_pid        = i_proc_id;
                    n_rd_idx     = '0;
                    n_cmp_vld    = 1'b0;
                    n_h_hit      = 1'b0;
                    n_id_hit     = 1'b0;
                    n_res_status = ST_OK;
                    n_res_parent = '0;
                    if (i_kind == K_ADD || i_kind == K_SET || i_kind == K_GET) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            S_SCAN: begin
                // compare the entry read last cycle; keep the first match of each kind
                if (r_cmp_vld) begin
                    if (!r_h_hit && rd_handle == r_handle) begin
                        n_h_hit = 1'b1;
                        n_h_idx = r_cmp_idx;
                        n_h_par = rd_par;
                    end
                    if (!r_id_hit && rd_id == r_pid) begin
                        n_id_hit = 1'b1;
                        n_id_idx = r_cmp_idx;
                        n_id_par = rd_par;
                    end
                end
                if (r_rd_idx < r_count) begin
                    ram_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[IW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_FIN;
                case (r_kind)
                    K_START: begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = {ALL_ONES, r_pid, {IW{1'b0}}};
                        n_count   = CW'(1);
                        n_running = 1'b1;
                        n_root    = r_pid;
                    end
                    K_STOP: begin
                        n_count   = '0;
                        n_running = 1'b0;
                    end
                    K_ADD: begin
                        if (r_count >= MAX_CNT) begin
                            n_res_status = ST_FULL;
                        end else if (r_h_hit) begin
                            n_res_status = ST_DUP;
                        end else if (!r_id_hit) begin
                            n_res_status = ST_NO_PARENT;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[IW-1:0];
                            ram_wdata = {r_handle, ALL_ONES, r_id_idx};
                            n_count   = r_count + CW'(1);
                        end
                    end
                    K_SET: begin
                        if (!r_h_hit) begin
                            n_res_status = ST_NOT_FOUND;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_h_idx;
                            ram_wdata = {ALL_ONES, r_pid, r_h_par};
                            if (r_h_idx == '0) begin
                                n_root = r_pid;
                            end
                        end
                    end
                    K_GET: begin
                        if (!r_id_hit) begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_parent = ALL_ONES;
                        end else if (r_id_idx == '0) begin
                            n_res_parent = ALL_ONES;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_id_par;
                            n_state   = S_PWAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_PWAIT: begin
                n_res_parent = rd_id;
                n_state      = S_FIN;
            end

            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_parent  = r_res_parent;
                    n_o_running = r_running;
                    n_o_child   = (r_count > CW'(1));
                    n_o_root    = r_root;
                    n_o_count   = r_count;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_h_hit     <= 1'b0;
            r_id_hit    <= 1'b0;
            r_root      <= ALL_ONES;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            r_rd_idx    <= n_rd_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_h_hit     <= n_h_hit;
            r_id_hit    <= n_id_hit;
            r_root      <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_handle     <= n_handle;
        r_pid        <= n_pid;
        r_cmp_idx    <= n_cmp_idx;
        r_h_idx      <= n_h_idx;
        r_h_par      <= n_h_par;
        r_id_idx     <= n_id_idx;
        r_id_par     <= n_id_par;
        r_res_status <= n_res_status;
        r_res_parent <= n_res_parent;
        r_o_status   <= n_o_status;
        r_o_parent   <= n_o_parent;
        r_o_running  <= n_o_running;
        r_o_child    <= n_o_child;
        r_o_root     <= n_o_root;
        r_o_count    <= n_o_count;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_parent_id   = r_o_parent;
    assign o_running     = r_o_running;
    assign o_found_child = r_o_child;
    assign o_root_id     = r_o_root;
    assign o_entry_count = COUNT_W'(r_o_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("entry count above table size");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_EXEC)
        else $error("entry write outside execute step");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_kind == K_ADD) |=>
            (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)))
        else $error("add changed count by more than one");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside final step");

    a_scan_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_re && !ram_we)
        else $error("memory access while idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/ptt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
